>>> rtl/assert_macros.svh
// assertion macros shared by the hsb converter rtl
// expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked at every edge, reset included
`define HSB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/hsb_pkg.sv
// types and constants for the hsb to rgb converter pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsb_pkg;

    localparam int HUE_W  = 16;
    localparam int UNIT_W = 17;
    localparam int WGT_W  = 33;
    localparam int PROD_W = 49;
    localparam int CHAN_W = 8;

    localparam logic [UNIT_W-1:0] UNIT_ONE = 17'h1_0000;
    localparam logic [WGT_W-1:0]  WGT_ONE  = 33'h1_0000_0000;

    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t           sector;
        logic [HUE_W-1:0]  frac;
        logic [UNIT_W-1:0] sat;
        logic [UNIT_W-1:0] val;
    } hsb_s1_t;

    typedef struct packed {
        sector_t           sector;
        logic [UNIT_W-1:0] val;
        logic [WGT_W-1:0]  wp;
        logic [WGT_W-1:0]  wq;
        logic [WGT_W-1:0]  wt;
    } hsb_s2_t;

    typedef struct packed {
        logic [PROD_W-1:0] r;
        logic [PROD_W-1:0] g;
        logic [PROD_W-1:0] b;
    } hsb_s3_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } hsb_rgb_t;

endpackage

`default_nettype wire

>>> rtl/hsb_to_rgb_converter.sv
// hsb to rgb converter top level: four-stage pipeline, one pixel per cycle
// depends on hsb_pkg, hsb_sector, hsb_weight, hsb_mult, hsb_round
//
// usage
//   input stream s_axis: one hue, saturation, brightness item per handshake
//   output stream m_axis: one 8-bit red, green, blue item per input item, in order
//   path: an accepted item passes the sector, weight, mult and round registers in order, the last driving m_tvalid
//   throughput: one item per cycle, set by the four register stages,
//     each holding one item with its own valid bit
//   stalls: each stage loads when it is empty or its successor takes its item,
//     so bubbles close up behind a stalled receiver; with all four stages full
//     and m_tready low, s_tready drops and nothing is lost or repeated
//   reset: aresetn low at a clock edge empties the pipeline, m_tvalid goes low
//   saturation and brightness above 65536 are clamped to 1.0; hue wraps
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsb_to_rgb_converter import hsb_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,  // hue_frac[15:0], sat_level[32:16], bright_level[49:33]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata   // red_out[7:0], green_out[15:8], blue_out[23:16]
);

    logic     v1, v2, v3;
    logic     r2, r3, r4;
    hsb_s1_t  d1;
    hsb_s2_t  d2;
    hsb_s3_t  d3;
    hsb_rgb_t d4;

    hsb_sector u_sector (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue       (s_tdata[15:0]),
        .sat       (s_tdata[32:16]),
        .val       (s_tdata[49:33]),
        .out_valid (v1),
        .out_ready (r2),
        .out_data  (d1)
    );

    hsb_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r2),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r3),
        .out_data  (d2)
    );

    hsb_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v2),
        .in_ready  (r3),
        .in_data   (d2),
        .out_valid (v3),
        .out_ready (r4),
        .out_data  (d3)
    );

    hsb_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v3),
        .in_ready  (r4),
        .in_data   (d3),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (d4)
    );

    assign m_tdata = {d4.blue, d4.green, d4.red};

    `HSB_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "output valid right after reset")
    `HSB_ASSERT(a_full_stall, (v1 && v2 && v3 && m_tvalid && !m_tready) |-> !s_tready, "input taken with full pipeline stalled")

endmodule

`default_nettype wire

>>> rtl/hsb_sector.sv
// stage 1: clamps saturation and brightness, splits hue*6 into sector and fraction
// depends on hsb_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsb_sector import hsb_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [HUE_W-1:0]  hue,
    input  wire logic [UNIT_W-1:0] sat,
    input  wire logic [UNIT_W-1:0] val,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output hsb_s1_t                out_data
);

    logic    valid_reg;
    hsb_s1_t data_reg;
    hsb_s1_t data_next;
    logic [HUE_W+2:0] h6;

    always_comb begin
        h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
        data_next.sector = sector_t'(h6[HUE_W+2:HUE_W]);
        data_next.frac   = h6[HUE_W-1:0];
        data_next.sat    = (sat > UNIT_ONE) ? UNIT_ONE : sat;
        data_next.val    = (val > UNIT_ONE) ? UNIT_ONE : val;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    `HSB_ASSERT(a_clamp_range, valid_reg |-> (data_reg.sat <= UNIT_ONE && data_reg.val <= UNIT_ONE), "clamped level above one")

endmodule

`default_nettype wire

>>> rtl/hsb_weight.sv
// stage 2: forms the p, q and t weights as 33-bit fractions of one
// depends on hsb_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsb_weight import hsb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire hsb_s1_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output hsb_s2_t      out_data
);

    logic    valid_reg;
    hsb_s2_t data_reg;
    hsb_s2_t data_next;
    logic [UNIT_W-1:0]  inv_frac;
    logic [UNIT_W-1:0]  inv_sat;
    logic [WGT_W:0]     sf;
    logic [WGT_W:0]     sfi;
    logic [WGT_W:0]     wq_full;
    logic [WGT_W:0]     wt_full;

    always_comb begin
        inv_frac = UNIT_ONE - {1'b0, in_data.frac};
        inv_sat  = UNIT_ONE - in_data.sat;
        sf       = {17'b0, in_data.sat} * {18'b0, in_data.frac};
        sfi      = {17'b0, in_data.sat} * {17'b0, inv_frac};
        wq_full  = {1'b0, WGT_ONE} - sf;
        wt_full  = {1'b0, WGT_ONE} - sfi;
        data_next.sector = in_data.sector;
        data_next.val    = in_data.val;
        data_next.wp     = {inv_sat, 16'h0000};
        data_next.wq     = wq_full[WGT_W-1:0];
        data_next.wt     = wt_full[WGT_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    `HSB_ASSERT(a_weight_range, valid_reg |-> (data_reg.wp <= WGT_ONE && data_reg.wq <= WGT_ONE && data_reg.wt <= WGT_ONE), "weight above one")

endmodule

`default_nettype wire

>>> rtl/hsb_mult.sv
// stage 3: orders the weights by sector and scales each by brightness
// depends on hsb_pkg
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsb_mult import hsb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire hsb_s2_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output hsb_s3_t      out_data
);

    localparam logic [PROD_W-1:0] PROD_ONE = 49'h1_0000_0000_0000;

    logic    valid_reg;
    hsb_s3_t data_reg;
    hsb_s3_t data_next;
    logic [WGT_W-1:0]  wr;
    logic [WGT_W-1:0]  wg;
    logic [WGT_W-1:0]  wb;
    logic [PROD_W:0]   pr;
    logic [PROD_W:0]   pg;
    logic [PROD_W:0]   pb;

    always_comb begin
        case (in_data.sector)
            SEC_RY: begin
                wr = WGT_ONE;    wg = in_data.wt; wb = in_data.wp;
            end
            SEC_YG: begin
                wr = in_data.wq; wg = WGT_ONE;    wb = in_data.wp;
            end
            SEC_GC: begin
                wr = in_data.wp; wg = WGT_ONE;    wb = in_data.wt;
            end
            SEC_CB: begin
                wr = in_data.wp; wg = in_data.wq; wb = WGT_ONE;
            end
            SEC_BM: begin
                wr = in_data.wt; wg = in_data.wp; wb = WGT_ONE;
            end
            default: begin
                wr = WGT_ONE;    wg = in_data.wp; wb = in_data.wq;
            end
        endcase
        pr = {33'b0, in_data.val} * {17'b0, wr};
        pg = {33'b0, in_data.val} * {17'b0, wg};
        pb = {33'b0, in_data.val} * {17'b0, wb};
        data_next.r = pr[PROD_W-1:0];
        data_next.g = pg[PROD_W-1:0];
        data_next.b = pb[PROD_W-1:0];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    `HSB_ASSERT(a_prod_range, valid_reg |-> (data_reg.r <= PROD_ONE && data_reg.g <= PROD_ONE && data_reg.b <= PROD_ONE), "channel product above one")

endmodule

`default_nettype wire

>>> rtl/hsb_round.sv
// stage 4: scales each channel by 255 and rounds half up into the output register
// depends on hsb_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsb_round import hsb_pkg::*; (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire hsb_s3_t in_data,
    output logic         out_valid,
    input  wire logic    out_ready,
    output hsb_rgb_t     out_data
);

    localparam int SC_W = PROD_W + CHAN_W;
    localparam int FRAC_BITS = PROD_W - 1;
    localparam logic [SC_W-1:0] HALF = SC_W'(1) << (FRAC_BITS - 1);

    logic     valid_reg;
    hsb_rgb_t data_reg;
    hsb_rgb_t data_next;
    logic [SC_W-1:0] sr;
    logic [SC_W-1:0] sg;
    logic [SC_W-1:0] sb;

    always_comb begin
        sr = {in_data.r, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, in_data.r} + HALF;
        sg = {in_data.g, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, in_data.g} + HALF;
        sb = {in_data.b, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, in_data.b} + HALF;
        data_next.red   = sr[FRAC_BITS+CHAN_W-1:FRAC_BITS];
        data_next.green = sg[FRAC_BITS+CHAN_W-1:FRAC_BITS];
        data_next.blue  = sb[FRAC_BITS+CHAN_W-1:FRAC_BITS];
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire
